// ----- hw/rtl/q2e_pkg.sv -----
// Shared types, widths and the arctangent table for the quaternion to Euler block.
package q2e_pkg;

    localparam int T_W       = 36;   // Q8.28 term width, covers non-unit inputs
    localparam int S_W       = 30;   // clamped asin argument, |t2| <= 2^28
    localparam int ANG_W     = 32;   // angle accumulator, 2^31 = pi
    localparam int TAB_SIZE  = 30;
    localparam int QDEPTH    = 4;
    localparam int QPTR_W    = 2;
    localparam int QCNT_W    = 3;
    localparam int ISQ_STEPS = 29;   // one result bit per step, 57-bit radicand
    localparam int ISQ_W     = 58;
    localparam int RAD_W     = 57;
    localparam int CX_W      = 38;   // CORDIC datapath, headroom for the gain

    typedef logic signed [T_W-1:0] t_term;
    typedef logic [ANG_W-1:0]      t_ang;

    typedef struct packed {
        t_term                 t0;
        t_term                 t1;
        t_term                 t3;
        t_term                 t4;
        logic signed [S_W-1:0] t2;
        logic                  clamped;
    } t_terms;

    localparam t_term ONE_Q28 = t_term'(64'sd268435456);

    // atan(2^-i), 2^32 per full turn
    localparam t_ang ATAN_TAB [TAB_SIZE] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
        32'd21354465,  32'd10679838,  32'd5340245,   32'd2670163,  32'd1335087,
        32'd667544,    32'd333772,    32'd166886,    32'd83443,    32'd41722,
        32'd20861,     32'd10430,     32'd5215,      32'd2608,     32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81,       32'd41,
        32'd20,        32'd10,        32'd5,         32'd3,        32'd1
    };

endpackage

// ----- hw/rtl/q2e_front.sv -----
// Front end: request intake, quaternion products and the five Q8.28 terms.
module q2e_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic signed [15:0]           i_quat_x,
    input  logic signed [15:0]           i_quat_y,
    input  logic signed [15:0]           i_quat_z,
    input  logic signed [15:0]           i_quat_w,
    input  logic [q2e_pkg::QCNT_W-1:0]   i_q_count,
    output logic                         o_push,
    output q2e_pkg::t_terms              o_terms
);
    import q2e_pkg::*;

    logic               r_v1, r_v2;
    logic signed [31:0] r_xx, r_yy, r_zz, r_wx, r_yz, r_wy, r_zx, r_wz, r_xy;
    t_terms             r_terms;
    t_terms             n_terms;
    logic [3:0]         n_load;
    logic               w_accept;
    t_term              w_t2;

    // credit: queue entries plus requests still in flight here
    assign n_load   = {1'b0, i_q_count} + {3'b0, r_v1} + {3'b0, r_v2};
    assign o_stall  = (n_load >= 4'(QDEPTH));
    assign w_accept = i_valid & ~o_stall;

    always_comb begin
        n_terms.t0 = (t_term'(r_wx) + t_term'(r_yz)) <<< 1;
        n_terms.t1 = ONE_Q28 - ((t_term'(r_xx) + t_term'(r_yy)) <<< 1);
        n_terms.t3 = (t_term'(r_wz) + t_term'(r_xy)) <<< 1;
        n_terms.t4 = ONE_Q28 - ((t_term'(r_yy) + t_term'(r_zz)) <<< 1);
        w_t2       = (t_term'(r_wy) - t_term'(r_zx)) <<< 1;
        if (w_t2 > ONE_Q28) begin
            n_terms.t2      = S_W'(ONE_Q28);
            n_terms.clamped = 1'b1;
        end else if (w_t2 < -ONE_Q28) begin
            n_terms.t2      = S_W'(-ONE_Q28);
            n_terms.clamped = 1'b1;
        end else begin
            n_terms.t2      = S_W'(w_t2);
            n_terms.clamped = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= w_accept;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_xx    <= i_quat_x * i_quat_x;
        r_yy    <= i_quat_y * i_quat_y;
        r_zz    <= i_quat_z * i_quat_z;
        r_wx    <= i_quat_w * i_quat_x;
        r_yz    <= i_quat_y * i_quat_z;
        r_wy    <= i_quat_w * i_quat_y;
        r_zx    <= i_quat_z * i_quat_x;
        r_wz    <= i_quat_w * i_quat_z;
        r_xy    <= i_quat_x * i_quat_y;
        r_terms <= n_terms;
    end

    assign o_push  = r_v2;
    assign o_terms = r_terms;

endmodule

// ----- hw/rtl/q2e_fifo.sv -----
// Short request queue between front and back end.
module q2e_fifo (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  q2e_pkg::t_terms            i_data,
    input  logic                       i_pop,
    output q2e_pkg::t_terms            o_data,
    output logic                       o_not_empty,
    output logic [q2e_pkg::QCNT_W-1:0] o_count
);
    import q2e_pkg::*;

    t_terms              r_mem [QDEPTH];
    logic [QPTR_W-1:0]   r_wp, r_rp;
    logic [QCNT_W-1:0]   r_count;
    logic                w_pop;

    assign o_not_empty = (r_count != '0);
    assign w_pop       = i_pop & o_not_empty;
    assign o_data      = r_mem[r_rp];
    assign o_count     = r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (w_pop)  r_rp <= r_rp + 1'b1;
            r_count <= r_count + QCNT_W'(i_push) - QCNT_W'(w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_data;
    end

endmodule

// ----- hw/rtl/q2e_cordic.sv -----
// Pipelined vectoring CORDIC lane, atan2(y, x) as a 32-bit binary angle.
module q2e_cordic #(
    parameter int STAGES = 16
) (
    input  logic                            i_clk,
    input  logic                            i_en,
    input  logic signed [q2e_pkg::CX_W-1:0] i_y,
    input  logic signed [q2e_pkg::CX_W-1:0] i_x,
    output q2e_pkg::t_ang                   o_angle
);
    import q2e_pkg::*;

    logic signed [CX_W-1:0] r_x [STAGES+1];
    logic signed [CX_W-1:0] r_y [STAGES+1];
    t_ang                   r_a [STAGES+1];
    logic                   r_z [STAGES+1];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // left half plane: turn by pi first
            if (i_x < 0) begin
                r_x[0] <= -i_x;
                r_y[0] <= -i_y;
                r_a[0] <= {1'b1, {(ANG_W-1){1'b0}}};
            end else begin
                r_x[0] <= i_x;
                r_y[0] <= i_y;
                r_a[0] <= '0;
            end
            r_z[0] <= (i_x == 0) && (i_y == 0);
            for (int i = 0; i < STAGES; i++) begin
                if (r_y[i] > 0) begin
                    r_x[i+1] <= r_x[i] + (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] - (r_x[i] >>> i);
                    r_a[i+1] <= r_a[i] + ATAN_TAB[i];
                end else begin
                    r_x[i+1] <= r_x[i] - (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] + (r_x[i] >>> i);
                    r_a[i+1] <= r_a[i] - ATAN_TAB[i];
                end
                r_z[i+1] <= r_z[i];
            end
        end
    end

    // zero vector gives angle zero
    assign o_angle = r_z[STAGES] ? '0 : r_a[STAGES];

endmodule

// ----- hw/rtl/q2e_back.sv -----
// Back end: asin radicand, pipelined square root, three CORDIC lanes, rounding.
module q2e_back #(
    parameter int CORDIC_STAGES = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_valid,
    input  q2e_pkg::t_terms    i_terms,
    output logic               o_pop,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [15:0] o_roll_angle,
    output logic signed [15:0] o_pitch_angle,
    output logic signed [15:0] o_yaw_angle,
    output logic               o_pitch_clamped
);
    import q2e_pkg::*;

    localparam int N = CORDIC_STAGES;

    logic                    w_en;
    logic signed [2*S_W-1:0] w_sq;
    logic [RAD_W-1:0]        w_rad;

    logic               r_iv [ISQ_STEPS+1];
    logic [ISQ_W-1:0]   r_iw [ISQ_STEPS+1];
    logic [ISQ_W-1:0]   r_ir [ISQ_STEPS+1];
    t_terms             r_it [ISQ_STEPS+1];

    logic               r_cv [N+1];
    logic               r_cc [N+1];

    logic signed [CX_W-1:0] w_px;
    t_ang                   w_roll_a, w_pitch_a, w_yaw_a;
    logic [ANG_W-1:0]       w_roll_r, w_yaw_r;
    logic signed [ANG_W:0]  w_ps;
    logic signed [16:0]     w_pq;
    logic signed [15:0]     w_pitch;

    logic               r_out_valid;
    logic signed [15:0] r_roll, r_pitch, r_yaw;
    logic               r_clamped;

    // whole back pipeline moves together when the output slot frees
    assign w_en  = ~r_out_valid | ~i_stall;
    assign o_pop = w_en & i_q_valid;

    assign w_sq  = i_terms.t2 * i_terms.t2;
    assign w_rad = ({1'b1, {(RAD_W-1){1'b0}}}) - w_sq[RAD_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= ISQ_STEPS; k++) r_iv[k] <= 1'b0;
            for (int k = 0; k <= N; k++) r_cv[k] <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_iv[0] <= i_q_valid;
            for (int k = 0; k < ISQ_STEPS; k++) r_iv[k+1] <= r_iv[k];
            r_cv[0] <= r_iv[ISQ_STEPS];
            for (int k = 0; k < N; k++) r_cv[k+1] <= r_cv[k];
            r_out_valid <= r_cv[N];
        end
    end

    // digit-by-digit square root, one result bit per stage
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_iw[0] <= ISQ_W'(w_rad);
            r_ir[0] <= '0;
            r_it[0] <= i_terms;
            for (int k = 0; k < ISQ_STEPS; k++) begin
                if (r_iw[k] >= r_ir[k] + (ISQ_W'(1) << (2*(ISQ_STEPS-1-k)))) begin
                    r_iw[k+1] <= r_iw[k] - (r_ir[k] + (ISQ_W'(1) << (2*(ISQ_STEPS-1-k))));
                    r_ir[k+1] <= (r_ir[k] >> 1) + (ISQ_W'(1) << (2*(ISQ_STEPS-1-k)));
                end else begin
                    r_iw[k+1] <= r_iw[k];
                    r_ir[k+1] <= r_ir[k] >> 1;
                end
                r_it[k+1] <= r_it[k];
            end
            r_cc[0] <= r_it[ISQ_STEPS].clamped;
            for (int k = 0; k < N; k++) r_cc[k+1] <= r_cc[k];
        end
    end

    assign w_px = CX_W'($signed({1'b0, r_ir[ISQ_STEPS][ISQ_STEPS-1:0]}));

    q2e_cordic #(.STAGES(N)) u_roll (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_y     (CX_W'(r_it[ISQ_STEPS].t0)),
        .i_x     (CX_W'(r_it[ISQ_STEPS].t1)),
        .o_angle (w_roll_a)
    );

    q2e_cordic #(.STAGES(N)) u_pitch (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_y     (CX_W'(r_it[ISQ_STEPS].t2)),
        .i_x     (w_px),
        .o_angle (w_pitch_a)
    );

    q2e_cordic #(.STAGES(N)) u_yaw (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_y     (CX_W'(r_it[ISQ_STEPS].t3)),
        .i_x     (CX_W'(r_it[ISQ_STEPS].t4)),
        .o_angle (w_yaw_a)
    );

    // round half up to 16 bits; pitch saturated to +-pi/2
    always_comb begin
        w_roll_r = w_roll_a + ANG_W'(32'h8000);
        w_yaw_r  = w_yaw_a + ANG_W'(32'h8000);
        w_ps     = $signed({w_pitch_a[ANG_W-1], w_pitch_a}) + 33'sd32768;
        w_pq     = w_ps[ANG_W:16];
        if (w_pq > 17'sd16384)       w_pitch = 16'sd16384;
        else if (w_pq < -17'sd16384) w_pitch = -16'sd16384;
        else                         w_pitch = w_pq[15:0];
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_roll    <= w_roll_r[ANG_W-1:16];
            r_yaw     <= w_yaw_r[ANG_W-1:16];
            r_pitch   <= w_pitch;
            r_clamped <= r_cc[N];
        end
    end

    assign o_valid         = r_out_valid;
    assign o_roll_angle    = r_roll;
    assign o_pitch_angle   = r_pitch;
    assign o_yaw_angle     = r_yaw;
    assign o_pitch_clamped = r_clamped;

endmodule

// ----- hw/rtl/quaternion_to_euler_angles.sv -----
// Top level: quaternion (Q2.14) to ZYX Euler binary angles.
//
//  channel | handshake            | payload
//  --------+----------------------+----------------------------------------------
//  input   | i_valid / o_stall    | i_quat_x, i_quat_y, i_quat_z, i_quat_w
//  output  | o_valid / i_stall    | o_roll_angle, o_pitch_angle, o_yaw_angle,
//          |                      | o_pitch_clamped
//
//  One request per cycle sustained while i_stall is low. A request passes the front end
//  (product and term registers), the queue, then the back end (square, 29 square-root
//  stages, pre-rotation, CORDIC stages, output register). The 4-entry queue decouples the fixed
//  front pipeline from the back pipeline, which freezes as a whole only while a finished
//  result is held by i_stall. o_stall comes from registers only (queue fill plus front
//  requests in flight). Reset is synchronous, active low; clears valid bits, queue pointers.
module quaternion_to_euler_angles #(
    parameter int CORDIC_STAGES = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [15:0] i_quat_x,
    input  logic signed [15:0] i_quat_y,
    input  logic signed [15:0] i_quat_z,
    input  logic signed [15:0] i_quat_w,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [15:0] o_roll_angle,
    output logic signed [15:0] o_pitch_angle,
    output logic signed [15:0] o_yaw_angle,
    output logic               o_pitch_clamped
);
    import q2e_pkg::*;

    logic              w_push, w_pop, w_not_empty;
    t_terms            w_front_terms, w_q_terms;
    logic [QCNT_W-1:0] w_count;

    // front: products and Q8.28 terms, credit-based intake
    q2e_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .i_quat_x  (i_quat_x),
        .i_quat_y  (i_quat_y),
        .i_quat_z  (i_quat_z),
        .i_quat_w  (i_quat_w),
        .i_q_count (w_count),
        .o_push    (w_push),
        .o_terms   (w_front_terms)
    );

    q2e_fifo u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_data      (w_front_terms),
        .i_pop       (w_pop),
        .o_data      (w_q_terms),
        .o_not_empty (w_not_empty),
        .o_count     (w_count)
    );

    // back: square root and three CORDIC lanes
    q2e_back #(.CORDIC_STAGES(CORDIC_STAGES)) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_valid       (w_not_empty),
        .i_terms         (w_q_terms),
        .o_pop           (w_pop),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_roll_angle    (o_roll_angle),
        .o_pitch_angle   (o_pitch_angle),
        .o_yaw_angle     (o_yaw_angle),
        .o_pitch_clamped (o_pitch_clamped)
    );

endmodule
